>>> design/lnh_pkg.sv
// ----------------------------------------------------------------------------
// lnh_pkg
// Shared types and constants for the link nonce handshake.
// ----------------------------------------------------------------------------
package lnh_pkg;

    localparam logic [7:0] SYNC0   = 8'h4D;
    localparam logic [7:0] SYNC1   = 8'h4C;
    localparam logic [7:0] T_HELLO = 8'h01;
    localparam logic [7:0] T_END   = 8'hFF;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] ST_HANDSHAKE = 2'd0;
    localparam logic [1:0] ST_CONNECTED = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;

    localparam logic       REG_GAME_ID      = 1'b0;
    localparam logic       REG_HELLO_PERIOD = 1'b1;

    localparam logic [15:0] HELLO_PERIOD_RESET = 16'd400;

    typedef logic [1:0] burst_kind_t;
    localparam burst_kind_t BURST_NONE  = 2'd0;
    localparam burst_kind_t BURST_HELLO = 2'd1;
    localparam burst_kind_t BURST_END   = 2'd2;

    localparam logic [3:0] HELLO_LEN = 4'd9;
    localparam logic [3:0] END_LEN   = 4'd3;

    typedef struct packed {
        burst_kind_t kind;
        logic [15:0] nonce;
        logic [1:0]  status;
        logic        is_host;
    } burst_t;

endpackage

>>> design/lnh_core.sv
// ----------------------------------------------------------------------------
// lnh_core
// Handshake state, nonce generator and receive framer; one transaction per
// load, producing the burst descriptor of the bytes to send.
// ----------------------------------------------------------------------------
module lnh_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [1:0]     req_type,
    input  logic [7:0]     rx_byte,
    input  logic [31:0]    seed,
    input  logic [31:0]    game_id,
    input  logic [15:0]    hello_period,
    output lnh_pkg::burst_t burst_next
);
    import lnh_pkg::*;

    logic [31:0] rng_reg, rng_next;
    logic [15:0] nonce_reg, nonce_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] timer_reg, timer_next;
    logic        hello_sent_reg, hello_sent_next;
    logic        resolved_reg, resolved_next;
    logic        end_sent_reg, end_sent_next;
    logic        end_seen_reg, end_seen_next;
    logic        host_reg, host_next;
    logic        mismatch_reg, mismatch_next;
    logic [7:0]  fb_reg [2:8];

    logic [31:0] rng_src;
    logic [31:0] rng_drawn;
    logic        active;
    logic        fb_we;
    logic [7:0]  frame_type;
    logic [3:0]  want;
    logic [3:0]  count_inc;
    logic [31:0] peer_gid;
    logic [15:0] remote_nonce;
    logic [15:0] timer_dec;
    burst_kind_t kind;

    assign rng_src   = (req_type == REQ_START) ? (seed | 32'd1) : rng_reg;
    assign rng_drawn = rng_src * LCG_MUL + LCG_INC;
    assign active    = !mismatch_reg && !(resolved_reg && end_sent_reg && end_seen_reg);
    assign frame_type = (count_reg == 4'd2) ? rx_byte : fb_reg[2];
    assign want = (frame_type == T_HELLO) ? HELLO_LEN :
                  (frame_type == T_END)   ? END_LEN : 4'd0;
    assign count_inc    = count_reg + 4'd1;
    assign peer_gid     = {fb_reg[6], fb_reg[5], fb_reg[4], fb_reg[3]};
    assign remote_nonce = {rx_byte, fb_reg[7]};
    assign timer_dec    = (timer_reg != 16'd0) ? timer_reg - 16'd1 : timer_reg;

    always_comb
    begin
        rng_next        = rng_reg;
        nonce_next      = nonce_reg;
        count_next      = count_reg;
        timer_next      = timer_reg;
        hello_sent_next = hello_sent_reg;
        resolved_next   = resolved_reg;
        end_sent_next   = end_sent_reg;
        end_seen_next   = end_seen_reg;
        host_next       = host_reg;
        mismatch_next   = mismatch_reg;
        fb_we           = 1'b0;
        kind            = BURST_NONE;
        case (req_type)
            REQ_START:
            begin
                rng_next        = rng_drawn;
                nonce_next      = rng_drawn[23:8];
                count_next      = 4'd0;
                timer_next      = 16'd0;
                hello_sent_next = 1'b0;
                resolved_next   = 1'b0;
                end_sent_next   = 1'b0;
                end_seen_next   = 1'b0;
                host_next       = 1'b0;
                mismatch_next   = 1'b0;
            end
            REQ_BYTE:
            begin
                if (active)
                begin
                    if (count_reg == 4'd0)
                    begin
                        if (rx_byte == SYNC0)
                            count_next = 4'd1;
                    end
                    else if (count_reg == 4'd1)
                    begin
                        if (rx_byte == SYNC1)
                            count_next = 4'd2;
                        else
                            count_next = (rx_byte == SYNC0) ? 4'd1 : 4'd0;
                    end
                    else if (count_reg >= 4'd9)
                    begin
                        count_next = 4'd0;
                    end
                    else
                    begin
                        fb_we = 1'b1;
                        if (want == 4'd0)
                            count_next = 4'd0;
                        else if (count_inc < want)
                            count_next = count_inc;
                        else
                        begin
                            count_next = 4'd0;
                            if (frame_type == T_HELLO)
                            begin
                                if (peer_gid != game_id)
                                    mismatch_next = 1'b1;
                                else
                                begin
                                    if (!resolved_reg)
                                    begin
                                        if (remote_nonce == nonce_reg)
                                        begin
                                            rng_next        = rng_drawn;
                                            nonce_next      = rng_drawn[23:8];
                                            hello_sent_next = 1'b0;
                                        end
                                        else
                                        begin
                                            resolved_next = 1'b1;
                                            host_next     = nonce_reg > remote_nonce;
                                        end
                                    end
                                    if (resolved_next && !end_sent_reg)
                                    begin
                                        kind          = BURST_END;
                                        end_sent_next = 1'b1;
                                    end
                                end
                            end
                            else
                                end_seen_next = 1'b1;
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                if (active)
                begin
                    timer_next = timer_dec;
                    if (!resolved_reg && (!hello_sent_reg || timer_dec == 16'd0))
                    begin
                        kind            = BURST_HELLO;
                        hello_sent_next = 1'b1;
                        timer_next      = hello_period;
                    end
                    if (resolved_reg && !end_sent_reg)
                    begin
                        kind          = BURST_END;
                        end_sent_next = 1'b1;
                    end
                end
            end
            default:
            begin
                kind = BURST_NONE;
            end
        endcase
    end

    always_comb
    begin
        burst_next.kind  = kind;
        burst_next.nonce = nonce_reg;
        if (mismatch_next)
            burst_next.status = ST_MISMATCH;
        else if (resolved_next && end_sent_next && end_seen_next)
            burst_next.status = ST_CONNECTED;
        else
            burst_next.status = ST_HANDSHAKE;
        burst_next.is_host = (burst_next.status == ST_CONNECTED) && host_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg        <= '0;
            nonce_reg      <= '0;
            count_reg      <= '0;
            timer_reg      <= '0;
            hello_sent_reg <= 1'b0;
            resolved_reg   <= 1'b0;
            end_sent_reg   <= 1'b0;
            end_seen_reg   <= 1'b0;
            host_reg       <= 1'b0;
            mismatch_reg   <= 1'b0;
        end
        else if (load)
        begin
            rng_reg        <= rng_next;
            nonce_reg      <= nonce_next;
            count_reg      <= count_next;
            timer_reg      <= timer_next;
            hello_sent_reg <= hello_sent_next;
            resolved_reg   <= resolved_next;
            end_sent_reg   <= end_sent_next;
            end_seen_reg   <= end_seen_next;
            host_reg       <= host_next;
            mismatch_reg   <= mismatch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && fb_we)
            fb_reg[count_reg] <= rx_byte;
    end

endmodule

>>> design/lnh_tx.sv
// ----------------------------------------------------------------------------
// lnh_tx
// Result register and byte sequencer: walks a HELLO, END or idle burst one
// result transaction per cycle while result_stall is low.
// ----------------------------------------------------------------------------
module lnh_tx (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  lnh_pkg::burst_t burst_in,
    input  logic [31:0]    game_id,
    input  logic           result_stall,
    output logic           result_valid,
    output logic           free,
    output logic           tx_valid,
    output logic [7:0]     tx_byte,
    output logic [1:0]     status,
    output logic           is_host,
    output logic           last
);
    import lnh_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    burst_t      burst_reg;
    logic [3:0]  len;
    logic        take;

    assign len  = (burst_reg.kind == BURST_HELLO) ? HELLO_LEN :
                  (burst_reg.kind == BURST_END)   ? END_LEN : 4'd1;
    assign last = (idx_reg == len - 4'd1);
    assign take = busy_reg && !result_stall;
    assign free = !busy_reg || (take && last);

    assign result_valid = busy_reg;
    assign tx_valid     = (burst_reg.kind != BURST_NONE);
    assign status       = burst_reg.status;
    assign is_host      = burst_reg.is_host;

    always_comb
    begin
        case (idx_reg)
            4'd0:    tx_byte = SYNC0;
            4'd1:    tx_byte = SYNC1;
            4'd2:    tx_byte = (burst_reg.kind == BURST_HELLO) ? T_HELLO : T_END;
            4'd3:    tx_byte = game_id[7:0];
            4'd4:    tx_byte = game_id[15:8];
            4'd5:    tx_byte = game_id[23:16];
            4'd6:    tx_byte = game_id[31:24];
            4'd7:    tx_byte = burst_reg.nonce[7:0];
            4'd8:    tx_byte = burst_reg.nonce[15:8];
            default: tx_byte = 8'h00;
        endcase
        if (burst_reg.kind == BURST_NONE)
            tx_byte = 8'h00;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 4'd1;
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst_in;
    end

endmodule

>>> design/link_nonce_handshake.sv
// ----------------------------------------------------------------------------
// link_nonce_handshake
// Peer nonce handshake over a byte link: framer, HELLO/END sender, resolve.
// Inputs are registered in s1, then loaded into the result register when the
//   byte sequencer is free. A burst is one idle result, 3 END bytes or 9 HELLO
//   bytes, emitted one result per cycle while result_stall is low.
// Reset: rst_n clears all handshake state; hello_period resets to 400.
// ----------------------------------------------------------------------------
module link_nonce_handshake (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] seed,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [1:0]  status,
    output logic        is_host,
    output logic        last
);
    import lnh_pkg::*;

    logic [31:0] game_id_reg;
    logic [15:0] period_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_req_reg;
    logic [7:0]  s1_byte_reg;
    logic [31:0] s1_seed_reg;
    logic        item_take;
    logic        advance;
    logic        tx_free;
    burst_t      burst_next;

    assign advance    = s1_valid_reg && tx_free;
    assign item_stall = s1_valid_reg && !tx_free;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            game_id_reg <= '0;
            period_reg  <= HELLO_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAME_ID:      game_id_reg <= cfg_data;
                REG_HELLO_PERIOD: period_reg  <= cfg_data[15:0];
                default:          game_id_reg <= game_id_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
            s1_valid_next = 1'b0;
        if (item_take)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_req_reg  <= req_type;
            s1_byte_reg <= rx_byte;
            s1_seed_reg <= seed;
        end
    end

    lnh_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .req_type     (s1_req_reg),
        .rx_byte      (s1_byte_reg),
        .seed         (s1_seed_reg),
        .game_id      (game_id_reg),
        .hello_period (period_reg),
        .burst_next   (burst_next)
    );

    lnh_tx u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .burst_in     (burst_next),
        .game_id      (game_id_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .free         (tx_free),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .status       (status),
        .is_host      (is_host),
        .last         (last)
    );

    // idle results carry a zero byte
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !tx_valid |-> tx_byte == 8'h00)
        else $error("idle result with nonzero byte");

    // host flag only reported once connected
    a_host_connected: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_host |-> status == ST_CONNECTED)
        else $error("is_host outside connected status");

    // a finished result ends the burst unless a new one is loaded
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && last && !s1_valid_reg |=> !result_valid)
        else $error("burst continued past last");

    // status stays put within one burst
    a_status_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> $stable(status))
        else $error("status changed inside a burst");

endmodule
